// ===== rtl/rndis_pkg.sv =====
// ----------------------------------------------------------------------------
// rndis_pkg: shared types and constants of the RNDIS host handshake block
// Phase, request and event codes, message constants, and the structs that
// carry state, event fields and results between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rndis_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_INIT  = 3'd1,
    PH_QMAC  = 3'd2,
    PH_QSIZE = 3'd3,
    PH_SETF  = 3'd4,
    PH_READY = 3'd5,
    PH_ERROR = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    FN_START    = 2'd0,
    FN_TEARDOWN = 2'd1,
    FN_RESPONSE = 2'd2,
    FN_KEEPALIVE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    K_INIT  = 2'd0,
    K_QUERY = 2'd1,
    K_SET   = 2'd2,
    K_KEEP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    LE_NONE = 2'd0,
    LE_UP   = 2'd1,
    LE_DOWN = 2'd2
  } link_event_t;

  // configuration register indexes
  localparam logic REG_XFER_SIZE = 1'b0;
  localparam logic REG_FILTER    = 1'b1;

  localparam logic [31:0] XFER_SIZE_RESET = 32'h0000_4000;
  localparam logic [31:0] FILTER_RESET    = 32'h0000_0007;

  // response message types
  localparam logic [31:0] T_INIT_CMPLT  = 32'h8000_0002;
  localparam logic [31:0] T_QUERY_CMPLT = 32'h8000_0004;
  localparam logic [31:0] T_SET_CMPLT   = 32'h8000_0005;
  localparam logic [31:0] T_KEEP_CMPLT  = 32'h8000_0008;

  // object ids
  localparam logic [31:0] OID_MAC    = 32'h0101_0102;
  localparam logic [31:0] OID_TOTAL  = 32'h0001_0111;
  localparam logic [31:0] OID_FILTER = 32'h0001_010E;
  localparam logic [31:0] STATUS_OK  = 32'h0000_0000;

  // request lengths in bytes
  localparam logic [5:0] LEN_INIT  = 6'd24;
  localparam logic [5:0] LEN_QUERY = 6'd28;
  localparam logic [5:0] LEN_SET   = 6'd32;
  localparam logic [5:0] LEN_KEEP  = 6'd12;

  // minimum response lengths in bytes
  localparam logic [31:0] MIN_HDR         = 32'd8;
  localparam logic [31:0] MIN_INIT_CMPLT  = 32'd52;
  localparam logic [31:0] MIN_QUERY_CMPLT = 32'd24;
  localparam logic [31:0] MIN_SET_CMPLT   = 32'd16;
  localparam logic [31:0] MIN_KEEP_CMPLT  = 32'd16;
  localparam logic [31:0] MAC_INFO_BYTES  = 32'd6;
  localparam logic [31:0] SIZE_INFO_BYTES = 32'd4;

  typedef struct packed {
    phase_t      phase;
    logic        ready;
    logic [31:0] req_id;
    logic [47:0] mac;
    logic [31:0] size;
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] msg_type;
    logic [31:0] msg_length;
    logic [31:0] resp_status;
    logic [31:0] resp_transfer_size;
    logic [31:0] info_length;
    logic [31:0] info_offset;
    logic [31:0] info_low_word;
    logic [15:0] info_high_half;
  } event_t;

  typedef struct packed {
    logic        send_valid;
    kind_t       send_kind;
    logic [5:0]  send_length;
    logic [31:0] send_request_id;
    logic [31:0] send_oid;
    logic [31:0] send_payload;
    phase_t      phase;
    logic        ready;
    link_event_t link_event;
    logic [47:0] mac;
    logic [31:0] size;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/rndis_step.sv =====
// ----------------------------------------------------------------------------
// rndis_step: next-state and result logic for one handshake event
// Decodes the event against the current phase, checks the response and
// forms the outgoing request, the new state and the reported fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rndis_step
  import rndis_pkg::*;
(
  input  state_t      st,
  input  event_t      ev,
  input  logic [31:0] xfer_size_cfg,
  input  logic [31:0] filter_cfg,
  output state_t      st_next,
  output result_t     res
);

  logic [33:0] info_end;
  logic        query_bad;
  logic        send;
  kind_t       kind;
  logic [5:0]  len;
  logic [31:0] oid;
  logic [31:0] payload;
  link_event_t lev;

  // bounds sum kept wide so it cannot wrap
  assign info_end  = {2'b00, ev.info_offset} + 34'(MIN_HDR) + {2'b00, ev.info_length};
  assign query_bad = (ev.msg_length < MIN_QUERY_CMPLT) || (ev.resp_status != STATUS_OK) ||
                     (info_end > {2'b00, ev.msg_length});

  always_comb begin
    st_next = st;
    send    = 1'b0;
    kind    = K_INIT;
    len     = '0;
    oid     = '0;
    payload = '0;
    lev     = LE_NONE;

    unique case (ev.func)
      FN_START: begin
        st_next.phase = PH_INIT;
        send    = 1'b1;
        kind    = K_INIT;
        len     = LEN_INIT;
        payload = xfer_size_cfg;
      end
      FN_TEARDOWN: begin
        st_next.phase = PH_IDLE;
        st_next.ready = 1'b0;
      end
      FN_KEEPALIVE: begin
        send = 1'b1;
        kind = K_KEEP;
        len  = LEN_KEEP;
      end
      FN_RESPONSE: begin
        if (ev.msg_length >= MIN_HDR) begin
          unique case (ev.msg_type)
            T_INIT_CMPLT: begin
              if (ev.msg_length < MIN_INIT_CMPLT || ev.resp_status != STATUS_OK) begin
                st_next.phase = PH_ERROR;
              end else begin
                st_next.size  = ev.resp_transfer_size;
                st_next.phase = PH_QMAC;
                send = 1'b1;
                kind = K_QUERY;
                len  = LEN_QUERY;
                oid  = OID_MAC;
              end
            end
            T_QUERY_CMPLT: begin
              if (st.phase == PH_QMAC || st.phase == PH_QSIZE) begin
                if (query_bad) begin
                  st_next.phase = PH_ERROR;
                end else if (st.phase == PH_QMAC && ev.info_length >= MAC_INFO_BYTES) begin
                  st_next.mac   = {ev.info_high_half, ev.info_low_word};
                  st_next.phase = PH_QSIZE;
                  send = 1'b1;
                  kind = K_QUERY;
                  len  = LEN_QUERY;
                  oid  = OID_TOTAL;
                end else if (st.phase == PH_QSIZE &&
                             ev.info_length >= SIZE_INFO_BYTES) begin
                  if (ev.info_low_word != '0) begin
                    st_next.size = ev.info_low_word;
                  end
                  st_next.phase = PH_SETF;
                  send    = 1'b1;
                  kind    = K_SET;
                  len     = LEN_SET;
                  oid     = OID_FILTER;
                  payload = filter_cfg;
                end
              end
            end
            T_SET_CMPLT: begin
              if (ev.msg_length < MIN_SET_CMPLT || ev.resp_status != STATUS_OK) begin
                st_next.phase = PH_ERROR;
              end else begin
                st_next.phase = PH_READY;
                st_next.ready = 1'b1;
                lev = LE_UP;
              end
            end
            T_KEEP_CMPLT: begin
              if (ev.msg_length >= MIN_KEEP_CMPLT && ev.resp_status != STATUS_OK) begin
                st_next.phase = PH_ERROR;
                st_next.ready = 1'b0;
                lev = LE_DOWN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    if (send) begin
      st_next.req_id = st.req_id + 32'd1;
    end

    res.send_valid      = send;
    res.send_kind       = kind;
    res.send_length     = len;
    res.send_request_id = send ? st.req_id : '0;
    res.send_oid        = oid;
    res.send_payload    = payload;
    res.phase           = st_next.phase;
    res.ready           = st_next.ready;
    res.link_event      = lev;
    res.mac             = st_next.mac;
    res.size            = st_next.size;
  end

endmodule

`default_nettype wire

// ===== rtl/rndis_host_init_handshake_unit.sv =====
// ----------------------------------------------------------------------------
// rndis_host_init_handshake_unit: host side of the RNDIS control handshake
//
// Event channel (evt_valid / evt_stall): one transaction carries a start,
// teardown, parsed control response or keepalive request.
// Result channel (res_valid / res_stall): exactly one transaction per event,
// holding the request to send (if any), the phase, the ready flag, the link
// event and the stored MAC address and transfer size after that event.
// APB port: register 0 at 0x0 is the offered transfer size, register 1 at
// 0x4 the packet filter; write only while no event is in flight.
//
// An event lands in the input register, then one pass of compare-and-update
// logic writes the state and the result register. Throughput is one event
// per cycle while the result is not stalled; the state feedback through that
// single pass sets the figure. The result register frees as it is taken, so
// a new event moves on while the previous result is being handed over.
// A stalled result holds its transaction; the input register then holds one
// more event and evt_stall rises until the result is taken.
// Reset clears the phase to idle, the ready flag, request id, MAC and size,
// and loads the register defaults (transfer size 0x4000, filter 7).
// ----------------------------------------------------------------------------
`default_nettype none

module rndis_host_init_handshake_unit
  import rndis_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // event channel
  input  wire logic        evt_valid,
  output logic             evt_stall,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] msg_type,
  input  wire logic [31:0] msg_length,
  input  wire logic [31:0] resp_status,
  input  wire logic [31:0] resp_transfer_size,
  input  wire logic [31:0] info_length,
  input  wire logic [31:0] info_offset,
  input  wire logic [31:0] info_low_word,
  input  wire logic [15:0] info_high_half,
  // result channel
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic             send_valid,
  output logic [1:0]       send_kind,
  output logic [5:0]       send_length,
  output logic [31:0]      send_request_id,
  output logic [31:0]      send_oid,
  output logic [31:0]      send_payload,
  output logic [2:0]       phase_now,
  output logic             link_ready,
  output logic [1:0]       link_event,
  output logic [47:0]      mac_address,
  output logic [31:0]      transfer_size
);

  logic [31:0] xfer_size_cfg;
  logic [31:0] filter_cfg;
  logic        cfg_write;
  logic        reg_sel;

  event_t      evt;
  logic        evt_full;
  logic        evt_take;
  logic        advance;

  state_t      st;
  state_t      st_next;
  result_t     res_next;
  result_t     res;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      xfer_size_cfg <= XFER_SIZE_RESET;
      filter_cfg    <= FILTER_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_XFER_SIZE: xfer_size_cfg <= pwdata;
        REG_FILTER:    filter_cfg    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_XFER_SIZE: prdata = xfer_size_cfg;
      REG_FILTER:    prdata = filter_cfg;
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // flow control: advance the held event whenever the result register is
  // free or being emptied this cycle
  // --------------------------------------------------------------------------
  assign advance   = evt_full && (!res_valid || !res_stall);
  assign evt_stall = evt_full && !advance;
  assign evt_take  = evt_valid && !evt_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_full <= 1'b0;
    end else if (evt_take) begin
      evt_full <= 1'b1;
    end else if (advance) begin
      evt_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_take) begin
      evt.func               <= func_t'(func);
      evt.msg_type           <= msg_type;
      evt.msg_length         <= msg_length;
      evt.resp_status        <= resp_status;
      evt.resp_transfer_size <= resp_transfer_size;
      evt.info_length        <= info_length;
      evt.info_offset        <= info_offset;
      evt.info_low_word      <= info_low_word;
      evt.info_high_half     <= info_high_half;
    end
  end

  // --------------------------------------------------------------------------
  // single-pass event logic
  // --------------------------------------------------------------------------
  rndis_step u_step (
    .st            (st),
    .ev            (evt),
    .xfer_size_cfg (xfer_size_cfg),
    .filter_cfg    (filter_cfg),
    .st_next       (st_next),
    .res           (res_next)
  );

  // handshake state: update only as an event passes through
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase  <= PH_IDLE;
      st.ready  <= 1'b0;
      st.req_id <= '0;
      st.mac    <= '0;
      st.size   <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign send_valid      = res.send_valid;
  assign send_kind       = res.send_kind;
  assign send_length     = res.send_length;
  assign send_request_id = res.send_request_id;
  assign send_oid        = res.send_oid;
  assign send_payload    = res.send_payload;
  assign phase_now       = res.phase;
  assign link_ready      = res.ready;
  assign link_event      = res.link_event;
  assign mac_address     = res.mac;
  assign transfer_size   = res.size;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the request id moves on by one for each emitted request and never else
  a_req_id_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> (st.req_id == $past(st.req_id) + {31'd0, $past(res_next.send_valid)}))
    else $error("request id did not follow emitted requests");

  // a link-up report always comes with the ready phase and the ready flag
  a_link_up_ready: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.link_event == LE_UP) |-> (res.ready && res.phase == PH_READY))
    else $error("link up without ready state");

  // a link-down report always leaves the block in error and not ready
  a_link_down_err: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.link_event == LE_DOWN) |-> (!res.ready && res.phase == PH_ERROR))
    else $error("link down without error state");

  // a result with no request carries cleared request fields
  a_no_req_clear: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.send_valid) |->
      (res.send_length == '0 && res.send_request_id == '0 &&
       res.send_oid == '0 && res.send_payload == '0))
    else $error("request fields set without a request");

  // the input side only stalls while an event is held
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    evt_stall |-> (evt_full && res_valid && res_stall))
    else $error("event stall without a held event");

endmodule

`default_nettype wire

// ===== test/rndis_host_init_handshake_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rndis_host_init_handshake_unit_tb: self-checking bench for the RNDIS host
// handshake block
// Drives start, teardown, keepalive and parsed response events into the event
// channel. A cycle-free predictor of the handshake works out each result, and
// a checker compares every result transaction field by field. Directed
// bring-up and corner cases come first. Random well-formed bring-up sequences
// mixed with noise follow under several register settings, with random gaps
// on the event channel and stalls on the result channel.
// ----------------------------------------------------------------------------

module rndis_host_init_handshake_unit_tb;
  import rndis_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any transaction
  localparam int DRAIN_CYCLES   = 4;     // two-stage pipeline plus margin
  localparam int MAX_REPORTS    = 10;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // APB port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // event channel
  logic        evt_valid = 1'b0;
  logic        evt_stall;
  logic [1:0]  func = '0;
  logic [31:0] msg_type = '0;
  logic [31:0] msg_length = '0;
  logic [31:0] resp_status = '0;
  logic [31:0] resp_transfer_size = '0;
  logic [31:0] info_length = '0;
  logic [31:0] info_offset = '0;
  logic [31:0] info_low_word = '0;
  logic [15:0] info_high_half = '0;

  // result channel
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        send_valid;
  logic [1:0]  send_kind;
  logic [5:0]  send_length;
  logic [31:0] send_request_id;
  logic [31:0] send_oid;
  logic [31:0] send_payload;
  logic [2:0]  phase_now;
  logic        link_ready;
  logic [1:0]  link_event;
  logic [47:0] mac_address;
  logic [31:0] transfer_size;

  // predictor copy of the block's state and registers
  phase_t      pred_phase   = PH_IDLE;
  logic        pred_ready   = 1'b0;
  logic [31:0] pred_req_id  = '0;
  logic [47:0] pred_mac     = '0;
  logic [31:0] pred_size    = '0;
  logic [31:0] cfg_xfer_size = XFER_SIZE_RESET;
  logic [31:0] cfg_filter    = FILTER_RESET;

  result_t pending_results[$];

  // idling switches, cleared for the final stretch
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;

  int events_sent   = 0;
  int results_taken = 0;
  int fault_count   = 0;
  int link_ups      = 0;
  int link_downs    = 0;
  int settings_used = 1;
  int stall_left    = 0;
  int quiet_cycles  = 0;

  rndis_host_init_handshake_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .evt_valid(evt_valid), .evt_stall(evt_stall),
    .func(func), .msg_type(msg_type), .msg_length(msg_length),
    .resp_status(resp_status), .resp_transfer_size(resp_transfer_size),
    .info_length(info_length), .info_offset(info_offset),
    .info_low_word(info_low_word), .info_high_half(info_high_half),
    .res_valid(res_valid), .res_stall(res_stall),
    .send_valid(send_valid), .send_kind(send_kind), .send_length(send_length),
    .send_request_id(send_request_id), .send_oid(send_oid),
    .send_payload(send_payload), .phase_now(phase_now),
    .link_ready(link_ready), .link_event(link_event),
    .mac_address(mac_address), .transfer_size(transfer_size)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Fill in an outgoing request and advance the request id (wraps mod 2^32).
  function automatic void issue_request(inout result_t r, input kind_t kind,
                                        input logic [5:0] len,
                                        input logic [31:0] oid,
                                        input logic [31:0] payload);
    r.send_valid      = 1'b1;
    r.send_kind       = kind;
    r.send_length     = len;
    r.send_request_id = pred_req_id;
    r.send_oid        = oid;
    r.send_payload    = payload;
    pred_req_id       = pred_req_id + 32'd1;
  endfunction

  // Apply one event to the predicted state and return the result it causes.
  function automatic result_t next_handshake_result(input event_t ev);
    result_t     r;
    logic [33:0] info_end;
    r = '0;
    // form the info bounds in 34 bits so that offset + 8 + length cannot wrap
    info_end = {2'b00, ev.info_offset} + 34'd8 + {2'b00, ev.info_length};
    case (ev.func)
      FN_START: begin
        pred_phase = PH_INIT;
        issue_request(r, K_INIT, LEN_INIT, 32'h0, cfg_xfer_size);
      end
      FN_TEARDOWN: begin
        pred_phase = PH_IDLE;
        pred_ready = 1'b0;
      end
      FN_KEEPALIVE: begin
        issue_request(r, K_KEEP, LEN_KEEP, 32'h0, 32'h0);
      end
      default: begin
        // anything shorter than the header is dropped outright
        if (ev.msg_length >= MIN_HDR) begin
          case (ev.msg_type)
            T_INIT_CMPLT: begin
              if (ev.msg_length < MIN_INIT_CMPLT || ev.resp_status != STATUS_OK) begin
                pred_phase = PH_ERROR;
              end else begin
                pred_size  = ev.resp_transfer_size;
                pred_phase = PH_QMAC;
                issue_request(r, K_QUERY, LEN_QUERY, OID_MAC, 32'h0);
              end
            end
            T_QUERY_CMPLT: begin
              // stray completions outside the query phases are ignored
              if (pred_phase == PH_QMAC || pred_phase == PH_QSIZE) begin
                if (ev.msg_length < MIN_QUERY_CMPLT || ev.resp_status != STATUS_OK ||
                    info_end > {2'b00, ev.msg_length}) begin
                  pred_phase = PH_ERROR;
                end else if (pred_phase == PH_QMAC && ev.info_length >= MAC_INFO_BYTES) begin
                  pred_mac   = {ev.info_high_half, ev.info_low_word};
                  pred_phase = PH_QSIZE;
                  issue_request(r, K_QUERY, LEN_QUERY, OID_TOTAL, 32'h0);
                end else if (pred_phase == PH_QSIZE &&
                             ev.info_length >= SIZE_INFO_BYTES) begin
                  // a reported size of zero keeps the stored one
                  if (ev.info_low_word != 32'h0) pred_size = ev.info_low_word;
                  pred_phase = PH_SETF;
                  issue_request(r, K_SET, LEN_SET, OID_FILTER, cfg_filter);
                end
              end
            end
            T_SET_CMPLT: begin
              if (ev.msg_length < MIN_SET_CMPLT || ev.resp_status != STATUS_OK) begin
                pred_phase = PH_ERROR;
              end else begin
                pred_phase   = PH_READY;
                pred_ready   = 1'b1;
                r.link_event = LE_UP;
              end
            end
            T_KEEP_CMPLT: begin
              if (ev.msg_length >= MIN_KEEP_CMPLT && ev.resp_status != STATUS_OK) begin
                pred_phase   = PH_ERROR;
                pred_ready   = 1'b0;
                r.link_event = LE_DOWN;
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase
    r.phase = pred_phase;
    r.ready = pred_ready;
    r.mac   = pred_mac;
    r.size  = pred_size;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Event builders
  // --------------------------------------------------------------------------

  // Random content in every field; the message type favours the known ones.
  function automatic event_t random_event(input func_t f);
    event_t ev;
    ev.func = f;
    case ($urandom_range(0, 4))
      0: ev.msg_type = T_INIT_CMPLT;
      1: ev.msg_type = T_QUERY_CMPLT;
      2: ev.msg_type = T_SET_CMPLT;
      3: ev.msg_type = T_KEEP_CMPLT;
      default: ev.msg_type = $urandom;
    endcase
    ev.msg_length         = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64) : $urandom;
    ev.resp_status        = ($urandom_range(0, 1) == 0) ? STATUS_OK : $urandom;
    ev.resp_transfer_size = $urandom;
    ev.info_length        = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 16) : $urandom;
    ev.info_offset        = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 16) : $urandom;
    ev.info_low_word      = $urandom;
    ev.info_high_half     = 16'($urandom);
    return ev;
  endfunction

  // A response of the given type; well formed unless good is clear, in which
  // case one way of breaking it is picked at random.
  function automatic event_t make_response(input logic [31:0] mtype,
                                           input logic [31:0] min_len,
                                           input bit good);
    event_t      ev;
    logic [31:0] span;
    ev.func               = FN_RESPONSE;
    ev.msg_type           = mtype;
    ev.resp_status        = STATUS_OK;
    ev.resp_transfer_size = ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom;
    ev.info_low_word      = ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom;
    ev.info_high_half     = 16'($urandom);
    ev.info_length        = $urandom_range(6, 24);
    ev.info_offset        = $urandom_range(0, 32);
    span                  = ev.info_offset + 32'd8 + ev.info_length;
    ev.msg_length         = ((span > min_len) ? span : min_len) + $urandom_range(0, 8);
    if (!good) begin
      case ($urandom_range(0, 4))
        0: ev.resp_status = $urandom | 32'h1;
        1: ev.msg_length  = $urandom_range(0, min_len - 1);
        2: ev.info_length = ev.msg_length;
        3: ev.info_offset = 32'hFFFF_FFFF - $urandom_range(0, 15);
        default: ev.info_length = $urandom_range(0, 5);
      endcase
    end
    return ev;
  endfunction

  function automatic event_t directed_response(input logic [31:0] mtype,
                                               input logic [31:0] len,
                                               input logic [31:0] status,
                                               input logic [31:0] ilen,
                                               input logic [31:0] ioff,
                                               input logic [31:0] lo,
                                               input logic [15:0] hi,
                                               input logic [31:0] xfer);
    event_t ev;
    ev.func               = FN_RESPONSE;
    ev.msg_type           = mtype;
    ev.msg_length         = len;
    ev.resp_status        = status;
    ev.resp_transfer_size = xfer;
    ev.info_length        = ilen;
    ev.info_offset        = ioff;
    ev.info_low_word      = lo;
    ev.info_high_half     = hi;
    return ev;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Send one event transaction. Entered and left just after a rising edge;
  // the payload holds until the edge at which the block takes it.
  task automatic send_event(input event_t ev);
    result_t r;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      evt_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    evt_valid          <= 1'b1;
    func               <= ev.func;
    msg_type           <= ev.msg_type;
    msg_length         <= ev.msg_length;
    resp_status        <= ev.resp_status;
    resp_transfer_size <= ev.resp_transfer_size;
    info_length        <= ev.info_length;
    info_offset        <= ev.info_offset;
    info_low_word      <= ev.info_low_word;
    info_high_half     <= ev.info_high_half;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    // accepted at this edge: predict now, in acceptance order
    r = next_handshake_result(ev);
    pending_results.push_back(r);
    events_sent++;
    if (r.link_event == LE_UP) link_ups++;
    if (r.link_event == LE_DOWN) link_downs++;
  endtask

  // Drop valid, wait for every pending result, then let the pipeline empty.
  task automatic settle();
    evt_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; written when pready is high.
  // Release the bus afterwards.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_XFER_SIZE) cfg_xfer_size = value;
    else cfg_filter = value;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] xfer, input logic [31:0] filter);
    settle();
    write_reg(REG_XFER_SIZE, xfer);
    write_reg(REG_FILTER, filter);
    settings_used++;
  endtask

  // Start, initialise, both queries and the filter set, at most one of the
  // last four broken, then up to three keepalives and perhaps a teardown.
  task automatic run_bring_up_sequence();
    int broken_at;
    int k;
    broken_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4;
    send_event(random_event(FN_START));
    send_event(make_response(T_INIT_CMPLT, MIN_INIT_CMPLT, broken_at != 0));
    send_event(make_response(T_QUERY_CMPLT, MIN_QUERY_CMPLT, broken_at != 1));
    send_event(make_response(T_QUERY_CMPLT, MIN_QUERY_CMPLT, broken_at != 2));
    send_event(make_response(T_SET_CMPLT, MIN_SET_CMPLT, broken_at != 3));
    k = $urandom_range(0, 3);
    repeat (k) begin
      send_event(random_event(FN_KEEPALIVE));
      send_event(make_response(T_KEEP_CMPLT, MIN_KEEP_CMPLT, $urandom_range(0, 4) != 0));
    end
    if ($urandom_range(0, 2) == 0) send_event(random_event(FN_TEARDOWN));
  endtask

  // Mostly well-formed sequences, the rest bursts of noise.
  task automatic run_traffic(input int n);
    int target;
    target = events_sent + n;
    while (events_sent < target) begin
      if ($urandom_range(0, 3) != 0) begin
        run_bring_up_sequence();
      end else begin
        repeat ($urandom_range(1, 4)) send_event(random_event(func_t'($urandom_range(0, 3))));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking and receiver stalls
  // --------------------------------------------------------------------------

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("mismatch in result %0d, %s: expected %0h, got %0h",
                 results_taken, name, want, got);
    end
  endfunction

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("result transaction %0d arrived with nothing pending", results_taken);
    end else begin
      want = pending_results.pop_front();
      compare_field("send_valid", 64'(want.send_valid), 64'(send_valid));
      compare_field("send_kind", 64'(want.send_kind), 64'(send_kind));
      compare_field("send_length", 64'(want.send_length), 64'(send_length));
      compare_field("send_request_id", 64'(want.send_request_id), 64'(send_request_id));
      compare_field("send_oid", 64'(want.send_oid), 64'(send_oid));
      compare_field("send_payload", 64'(want.send_payload), 64'(send_payload));
      compare_field("phase_now", 64'(want.phase), 64'(phase_now));
      compare_field("link_ready", 64'(want.ready), 64'(link_ready));
      compare_field("link_event", 64'(want.link_event), 64'(link_event));
      compare_field("mac_address", 64'(want.mac), 64'(mac_address));
      compare_field("transfer_size", 64'(want.size), 64'(transfer_size));
    end
    results_taken++;
  endtask

  // Take results at the edge where valid is high and stall low, and hold the
  // stall in random bursts while stalls are enabled.
  always @(posedge clk) begin
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid && !res_stall) check_result();
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 9);
        res_stall  <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // Watchdog: give up once neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (evt_valid && !evt_stall) || (res_valid && !res_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 quiet_cycles, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Full bring-up with the reset register values, then keepalive both ways.
  task automatic test_bring_up();
    send_event(random_event(FN_START));
    send_event(directed_response(T_INIT_CMPLT, MIN_INIT_CMPLT, STATUS_OK,
                                 0, 0, 0, 0, 32'hFFFF_FFFF));
    // info ends exactly at the message end: 10 + 8 + 6 = 24
    send_event(directed_response(T_QUERY_CMPLT, MIN_QUERY_CMPLT, STATUS_OK,
                                 6, 10, 32'hFFFF_FFFF, 16'hFFFF, 0));
    // zero total size keeps the size from the initialise completion
    send_event(directed_response(T_QUERY_CMPLT, 32'hFFFF_FFFF, STATUS_OK, 4, 0, 0, 0, 0));
    send_event(directed_response(T_SET_CMPLT, MIN_SET_CMPLT, STATUS_OK, 0, 0, 0, 0, 0));
    send_event(random_event(FN_KEEPALIVE));
    send_event(directed_response(T_KEEP_CMPLT, MIN_KEEP_CMPLT, STATUS_OK, 0, 0, 0, 0, 0));
    send_event(directed_response(T_KEEP_CMPLT, MIN_KEEP_CMPLT, 32'hFFFF_FFFF,
                                 0, 0, 0, 0, 0));
  endtask

  // Ignored, rejected and short responses across the phases.
  task automatic test_special_cases();
    send_event(random_event(FN_TEARDOWN));
    send_event(directed_response(T_SET_CMPLT, 7, STATUS_OK, 0, 0, 0, 0, 0));
    send_event(directed_response(32'h0, 64, STATUS_OK, 0, 0, 0, 0, 0));
    // query completion while idle
    send_event(directed_response(T_QUERY_CMPLT, 24, STATUS_OK, 6, 0, $urandom, 0, 0));
    send_event(random_event(FN_START));
    send_event(directed_response(T_INIT_CMPLT, 51, STATUS_OK, 0, 0, 0, 0, 1));
    send_event(random_event(FN_START));
    send_event(directed_response(T_INIT_CMPLT, 52, 32'h1, 0, 0, 0, 0, 1));
    send_event(random_event(FN_START));
    send_event(directed_response(T_INIT_CMPLT, 52, STATUS_OK, 0, 0, 0, 0, 0));
    // too few MAC bytes: nothing changes
    send_event(directed_response(T_QUERY_CMPLT, 24, STATUS_OK, 5, 0, $urandom, 0, 0));
    // bounds that would wrap in 32 bits
    send_event(directed_response(T_QUERY_CMPLT, 32'hFFFF_FFFF, STATUS_OK,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
    send_event(directed_response(T_SET_CMPLT, 15, STATUS_OK, 0, 0, 0, 0, 0));
    send_event(directed_response(T_SET_CMPLT, 16, 32'h8000_0000, 0, 0, 0, 0, 0));
    // short keepalive completion is ignored despite the bad status
    send_event(directed_response(T_KEEP_CMPLT, 15, 32'h1, 0, 0, 0, 0, 0));
    send_event(random_event(FN_START));
    send_event(directed_response(T_INIT_CMPLT, 52, STATUS_OK, 0, 0, 0, 0, 32'h600));
    send_event(directed_response(T_QUERY_CMPLT, 24, STATUS_OK, 6, 0,
                                 32'h0403_0201, 16'h0605, 0));
    // too few size bytes, then a short query completion
    send_event(directed_response(T_QUERY_CMPLT, 24, STATUS_OK, 3, 0, 32'h1234, 0, 0));
    send_event(directed_response(T_QUERY_CMPLT, 23, STATUS_OK, 4, 0, 32'h1234, 0, 0));
  endtask

  // Both registers at their extremes.
  task automatic test_register_extremes();
    apply_settings(32'h0, 32'h0);
    run_traffic(150);
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_traffic(150);
  endtask

  // Random settings with gaps on the event channel and stalls on the result channel.
  task automatic test_random_traffic();
    repeat (4) begin
      apply_settings($urandom, $urandom);
      run_traffic(125);
    end
  endtask

  // Final stretch at full rate: no gaps, no stalls.
  task automatic test_full_rate();
    apply_settings($urandom, $urandom);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_traffic(150);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_bring_up();
    test_special_cases();
    test_register_extremes();
    test_random_traffic();
    test_full_rate();
    settle();

    // anything still pending at this point never arrived
    fault_count += pending_results.size();
    $display("Ran %0d events and checked %0d results under %0d register settings.",
             events_sent, results_taken, settings_used);
    $display("Saw %0d link-up and %0d link-down events; %0d failures.",
             link_ups, link_downs, fault_count);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
